>>> hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that a condition leads to another one on the next rising clock edge.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

>>> hdl/bsl_pkg.sv
package bsl_pkg;

  localparam int Depth = 16;
  localparam int IdxW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam int CapW  = 5;
  localparam int PosW  = 5;
  localparam int LenW  = 5;
  localparam int DataW = 32;

  localparam logic [CapW-1:0] CapReset = 5'd10;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_HEAD   = 2'd1,
    FUNC_TAIL   = 2'd2,
    FUNC_READ   = 2'd3
  } bsl_func_e;

  typedef struct packed {
    bsl_func_e               func;
    logic [PosW-1:0]         position;
    logic signed [DataW-1:0] value;
  } bsl_in_t;

  typedef struct packed {
    logic                    ok;
    logic signed [DataW-1:0] read_value;
    logic [LenW-1:0]         length;
  } bsl_out_t;

  typedef struct packed {
    logic exec;
  } bsl_cmd_t;

endpackage

>>> hdl/bsl_ctrl.sv
module bsl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bsl_pkg::bsl_cmd_t cmd_o
);
  import bsl_pkg::*;

  typedef enum logic {
    ST_EMPTY,
    ST_FULL
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o  = (state_q == ST_EMPTY) || out_ready_i;
  assign out_valid_o = (state_q == ST_FULL);
  assign cmd_o.exec  = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_EMPTY: begin
        if (cmd_o.exec) state_d = ST_FULL;
      end
      ST_FULL: begin
        if (cmd_o.exec) begin
          state_d = ST_FULL;
        end else if (out_ready_i) begin
          state_d = ST_EMPTY;
        end
      end
      default: state_d = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hdl/bsl_dp.sv
module bsl_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bsl_pkg::bsl_cmd_t         cmd_i,
  input  logic                      cfg_we_i,
  input  logic [bsl_pkg::CapW-1:0]  cfg_wdata_i,
  input  bsl_pkg::bsl_in_t          in_data_i,
  output bsl_pkg::bsl_out_t         out_data_o
);
  import bsl_pkg::*;

  logic signed [DataW-1:0] entries_q [Depth];
  logic signed [DataW-1:0] entries_d [Depth];
  logic signed [DataW-1:0] shifted   [Depth];
  logic [CntW-1:0]         count_q, count_d;
  logic [CapW-1:0]         capacity_q;
  bsl_out_t                result_q, result_d;

  logic [CntW-1:0]         limit;
  logic                    has_room;
  logic [PosW-1:0]         pos_m1;
  logic [IdxW-1:0]         rd_idx;
  logic                    read_ok;
  logic                    insert_ok;
  logic [CntW-1:0]         slot;
  logic [CntW-1:0]         pos_c;

  assign limit    = (CntW'(capacity_q) > CntW'(Depth)) ? CntW'(Depth) : CntW'(capacity_q);
  assign has_room = count_q < limit;
  assign pos_m1   = in_data_i.position - PosW'(1);
  assign rd_idx   = pos_m1[IdxW-1:0];
  assign pos_c    = CntW'(in_data_i.position);
  assign read_ok  = (in_data_i.func == FUNC_READ) && (in_data_i.position != '0)
                    && (pos_c <= count_q);

  always_comb begin
    insert_ok = 1'b0;
    slot      = '0;
    unique case (in_data_i.func)
      FUNC_INSERT: begin
        insert_ok = has_room && (in_data_i.position != '0) && (pos_c <= count_q + CntW'(1));
        slot      = CntW'(pos_m1);
      end
      FUNC_HEAD: begin
        insert_ok = has_room;
        slot      = '0;
      end
      FUNC_TAIL: begin
        insert_ok = has_room;
        slot      = count_q;
      end
      FUNC_READ: begin
        insert_ok = 1'b0;
        slot      = '0;
      end
      default: begin
        insert_ok = 1'b0;
        slot      = '0;
      end
    endcase
  end

  always_comb begin
    shifted[0] = entries_q[0];
    for (int i = 1; i < Depth; i++) begin
      shifted[i] = entries_q[i-1];
    end
  end

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      if (CntW'(i) == slot) begin
        entries_d[i] = in_data_i.value;
      end else if ((CntW'(i) > slot) && (CntW'(i) <= count_q)) begin
        entries_d[i] = shifted[i];
      end else begin
        entries_d[i] = entries_q[i];
      end
    end
  end

  assign count_d             = insert_ok ? count_q + CntW'(1) : count_q;
  assign result_d.ok         = read_ok || insert_ok;
  assign result_d.read_value = read_ok ? entries_q[rd_idx] : '0;
  assign result_d.length     = LenW'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      capacity_q <= CapReset;
    end else begin
      if (cmd_i.exec) count_q <= count_d;
      if (cfg_we_i) capacity_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      result_q <= result_d;
      if (insert_ok) begin
        for (int i = 0; i < Depth; i++) begin
          entries_q[i] <= entries_d[i];
        end
      end
    end
  end

  assign out_data_o = result_q;

endmodule

>>> hdl/bounded_sequential_list_top.sv
// Bounded list of signed 32-bit entries with insert, head insert, append and read.
// Input channel in_valid_i/in_ready_o carries one request (func, position, value);
// output channel out_valid_o/out_ready_i carries one result (ok, read_value, length).
// Every request gives exactly one result, in request order.
// Latency: a result is valid the cycle after its request is accepted.
// Throughput: one request per cycle; the whole insert shift and the read run in the
// accept cycle on a register array whose cells shift in parallel.
// A new request is taken while a result waits, as long as that result is taken in the
// same cycle; when the receiver stalls, the held result blocks further requests.
// cfg_we_i/cfg_wdata_i write the capacity register (limit saturates at 16 entries);
// write it only while no transaction is in flight.
// Reset clears the length to zero, sets capacity to 10 and marks the output register empty.
// Entry storage is not cleared; only entries below the current length are ever read.
module bounded_sequential_list_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  bsl_pkg::bsl_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output bsl_pkg::bsl_out_t         out_data_o,
  input  logic                      cfg_we_i,
  input  logic [bsl_pkg::CapW-1:0]  cfg_wdata_i
);
  import bsl_pkg::*;

  bsl_cmd_t cmd;

  bsl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  bsl_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> hdl/bsl_checker.sv
`include "assert_macros.svh"

module bsl_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input bsl_pkg::bsl_out_t         out_data_o
);
  import bsl_pkg::*;

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `ASSERT_NEXT(a_result_follows, clk_i, rst_ni, in_valid_i && in_ready_o, out_valid_o)
  `ASSERT_CLK(a_ready_when_empty, clk_i, rst_ni, !out_valid_o |-> in_ready_o)
  `ASSERT_CLK(a_len_bound, clk_i, rst_ni, out_valid_o |-> out_data_o.length <= LenW'(Depth))
  `ASSERT_CLK(a_reject_zero, clk_i, rst_ni,
    out_valid_o && !out_data_o.ok |-> out_data_o.read_value == '0)

endmodule

bind bounded_sequential_list_top bsl_checker u_bsl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

>>> test/tb_bounded_sequential_list_top.sv
`timescale 1ns / 100ps

module tb_bounded_sequential_list_top;
  import bsl_pkg::*;

  localparam int CycleLimit = 200000;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  bsl_in_t         in_data_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  bsl_out_t        out_data_o;
  logic            cfg_we_i = 1'b0;
  logic [CapW-1:0] cfg_wdata_i = '0;

  bounded_sequential_list_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the list contents, its length and the capacity register
  logic signed [DataW-1:0] list_mem [Depth];
  int                      list_len = 0;
  logic [CapW-1:0]         cap_q = CapReset;

  bsl_out_t expected_results [$];
  bit       idle_en = 1'b1;
  int       fail_cnt = 0;
  int       result_cnt = 0;
  int       insert_ok_cnt = 0;
  int       read_hit_cnt = 0;
  int       cap_write_cnt = 0;
  int       cycle_cnt = 0;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic bsl_out_t apply_list_op(bsl_in_t req);
    bsl_out_t res;
    int       lim;
    int       pos;
    int       slot;
    int       j;
    res  = '0;
    slot = -1;
    lim  = (cap_q > Depth) ? Depth : int'(cap_q);
    pos  = req.position;
    if (req.func == FUNC_READ) begin
      if (pos >= 1 && pos <= list_len) begin
        res.ok         = 1'b1;
        res.read_value = list_mem[pos-1];
        read_hit_cnt++;
      end
    end else if (list_len < lim) begin
      case (req.func)
        FUNC_INSERT: begin
          if (pos >= 1 && pos <= list_len + 1) slot = pos - 1;
        end
        FUNC_HEAD: begin
          slot = 0;
        end
        default: begin
          slot = list_len;
        end
      endcase
      if (slot >= 0) begin
        for (j = list_len; j > slot; j--) list_mem[j] = list_mem[j-1];
        list_mem[slot] = req.value;
        list_len++;
        res.ok = 1'b1;
        insert_ok_cnt++;
      end
    end
    res.length = LenW'(list_len);
    return res;
  endfunction

  task automatic check_result(bsl_out_t got);
    bsl_out_t exp_res;
    result_cnt++;
    if (expected_results.size() == 0) begin
      $error("unexpected result transaction: %p", got);
      fail_cnt++;
      return;
    end
    exp_res = expected_results.pop_front();
    if (got.ok !== exp_res.ok) begin
      $error("ok mismatch: expected %0d, actual %0d", exp_res.ok, got.ok);
      fail_cnt++;
    end
    if (got.read_value !== exp_res.read_value) begin
      $error("read_value mismatch: expected %0d, actual %0d",
             exp_res.read_value, got.read_value);
      fail_cnt++;
    end
    if (got.length !== exp_res.length) begin
      $error("length mismatch: expected %0d, actual %0d", exp_res.length, got.length);
      fail_cnt++;
    end
  endtask

  initial begin : result_monitor
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        check_result(out_data_o);
        stall = idle_en ? $urandom_range(0, 13) : 0;
      end else if (stall > 0) begin
        stall--;
      end
      out_ready_i <= (stall == 0);
    end
  end

  task automatic push_request(bsl_in_t req);
    int gap;
    gap = idle_en ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(apply_list_op(req));
  endtask

  task automatic drive_op(bsl_func_e func, int pos, logic signed [DataW-1:0] val);
    bsl_in_t req;
    req.func     = func;
    req.position = PosW'(pos);
    req.value    = val;
    push_request(req);
  endtask

  task automatic settle_list();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CapW-1:0] cap);
    settle_list();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cap_q = cap;
    cap_write_cnt++;
  endtask

  function automatic bsl_in_t random_request();
    bsl_in_t req;
    int      hi;
    req.func = bsl_func_e'(2'($urandom_range(0, 3)));
    hi = (req.func == FUNC_READ) ? list_len : list_len + 1;
    if (hi == 0 || $urandom_range(0, 9) < 2) req.position = PosW'($urandom_range(0, 31));
    else req.position = PosW'($urandom_range(1, hi));
    case ($urandom_range(0, 7))
      0:       req.value = 32'sh8000_0000;
      1:       req.value = 32'sh7fff_ffff;
      2:       req.value = '0;
      default: req.value = $urandom;
    endcase
    return req;
  endfunction

  task automatic test_empty_list();
    drive_op(FUNC_READ, 0, 32'sd0);
    drive_op(FUNC_READ, 31, 32'sd0);
    drive_op(FUNC_INSERT, 0, 32'sd5);
    drive_op(FUNC_INSERT, 2, 32'sd6);
  endtask

  task automatic test_capacity_zero();
    write_capacity(5'd0);
    drive_op(FUNC_HEAD, 0, 32'sd1);
    drive_op(FUNC_TAIL, 0, 32'sd2);
    drive_op(FUNC_INSERT, 1, 32'sd3);
  endtask

  task automatic test_capacity_one();
    write_capacity(5'd1);
    drive_op(FUNC_INSERT, 1, 32'sh8000_0000);
    drive_op(FUNC_HEAD, 0, 32'sd7);
    drive_op(FUNC_TAIL, 0, 32'sd8);
    drive_op(FUNC_READ, 1, 32'sd0);
    drive_op(FUNC_READ, 2, 32'sd0);
  endtask

  task automatic test_insert_ops();
    int p;
    write_capacity(CapReset);
    drive_op(FUNC_HEAD, 0, 32'sh7fff_ffff);
    drive_op(FUNC_TAIL, 0, -32'sd1);
    drive_op(FUNC_INSERT, 2, 32'sd0);
    drive_op(FUNC_INSERT, 5, 32'sh5a5a_a5a5);
    drive_op(FUNC_INSERT, 7, 32'sd9);
    drive_op(FUNC_INSERT, 0, 32'sd9);
    for (p = 1; p <= 6; p++) drive_op(FUNC_READ, p, 32'sd0);
  endtask

  task automatic test_random_phase(int n_items, logic [CapW-1:0] cap, bit idle);
    int i;
    write_capacity(cap);
    idle_en = idle;
    for (i = 0; i < n_items; i++) push_request(random_request());
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_capacity_zero();
    test_capacity_one();
    test_insert_ops();

    test_random_phase(150, 5'd12, 1'b0);
    test_random_phase(300, 5'($urandom_range(0, 31)), 1'b1);
    test_random_phase(300, 5'd16, 1'b1);
    test_random_phase(250, 5'd31, 1'b0);
    test_random_phase(250, 5'd0, 1'b1);

    settle_list();
    repeat (5) @(posedge clk_i);
    $display("Checked %0d results over %0d capacity settings", result_cnt, cap_write_cnt);
    $display("%0d inserts and %0d reads succeeded, final length %0d",
             insert_ok_cnt, read_hit_cnt, list_len);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/bsl_pkg.sv
hdl/bsl_ctrl.sv
hdl/bsl_dp.sv
hdl/bounded_sequential_list_top.sv
hdl/bsl_checker.sv
test/tb_bounded_sequential_list_top.sv
